/* rtl/buzzer_melody_sequencer_assert.svh */
// Assertion macros for the buzzer melody sequencer.
// BMS_ASSERT_IMP checks a same-cycle implication, BMS_ASSERT_NXT a next-cycle one.
// Both sample on i_clk and stay quiet while i_rst_n is low.
`ifndef BUZZER_MELODY_SEQUENCER_ASSERT_SVH
`define BUZZER_MELODY_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

`define BMS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BMS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BMS_ASSERT_IMP(name, ante, cons, msg)

`define BMS_ASSERT_NXT(name, ante, cons, msg)

`endif

`endif

/* rtl/bms_pkg.sv */
package bms_pkg;

    // Field widths
    localparam int FREQ_W     = 17;
    localparam int DUR_W      = 16;
    localparam int NOTE_W     = FREQ_W + DUR_W;
    localparam int PERIOD_W   = 26;
    localparam int HIGH_W     = 23;
    localparam int ELAPSED_W  = 17;
    localparam int TUNE_W     = 3;
    localparam int POS_W      = 3;
    localparam int CNT_W      = 3;
    localparam int LEN_W      = 4;
    localparam int CFG_IDX_W  = 3;

    // Behavior constants
    localparam int TICK_STEP    = 20;
    localparam int MAX_NOTES    = 6;
    localparam int STORED_NOTES = 6;
    localparam int PRESET_COUNT = 5;

    localparam logic [PERIOD_W-1:0]  PWM_CLOCK   = 26'd40000000;
    localparam logic [PERIOD_W-1:0]  PERIOD_MAX  = 26'd67108863;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'd131071;
    localparam logic [POS_W-1:0]     STORED_LAST = POS_W'(STORED_NOTES - 1);

    // Divide by 10 through a reciprocal: floor(n * ceil(2^35/10) / 2^35) is exact below 2^26
    localparam int               RECIP_W     = 32;
    localparam int               RECIP_SHIFT = 35;
    localparam int               PRODUCT_W   = PERIOD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_10  = 32'd3435973837;

    // Serial divider
    localparam int                  DIV_STEPS = PERIOD_W;
    localparam int                  DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // Tune selection codes
    localparam logic [TUNE_W-1:0] TUNE_CLICK     = 3'd0;
    localparam logic [TUNE_W-1:0] TUNE_POWER_ON  = 3'd1;
    localparam logic [TUNE_W-1:0] TUNE_LOW_POWER = 3'd2;
    localparam logic [TUNE_W-1:0] TUNE_WORK      = 3'd3;
    localparam logic [TUNE_W-1:0] TUNE_PAIR      = 3'd4;
    localparam logic [TUNE_W-1:0] TUNE_CUSTOM    = 3'd5;
    localparam logic [TUNE_W-1:0] TUNE_NONE      = 3'd7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_3     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_4     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_5     = 3'd6;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_PRESET = 2'd1,
        KIND_CUSTOM = 2'd2,
        KIND_STOP   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [DUR_W-1:0]  dur;
    } t_note;

    localparam t_note NOTE_RESET_0 = 33'd131073000;

    // Micro-operations
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_ACCEPT,
        UOP_COMMAND,
        UOP_BEGIN,
        UOP_ADVANCE,
        UOP_DIV_LOAD,
        UOP_DIV_STEP,
        UOP_SCALE_MUL,
        UOP_SCALE_OUT,
        UOP_EMIT
    } t_uop;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_NO_NOTE_TICK,
        COND_PHASE_ON,
        COND_NO_PROGRAM,
        COND_DIV_BUSY,
        COND_OUT_STALL
    } t_ucond;

    typedef logic [3:0] t_upc;

    localparam t_upc UPC_FETCH    = 4'd0;
    localparam t_upc UPC_DISPATCH = 4'd1;
    localparam t_upc UPC_TEST     = 4'd2;
    localparam t_upc UPC_BEGIN    = 4'd3;
    localparam t_upc UPC_ADVANCE  = 4'd4;
    localparam t_upc UPC_DIV_LOAD = 4'd5;
    localparam t_upc UPC_DIV_STEP = 4'd6;
    localparam t_upc UPC_MUL      = 4'd7;
    localparam t_upc UPC_SCALE    = 4'd8;
    localparam t_upc UPC_EMIT     = 4'd9;
    localparam t_upc UPC_RETURN   = 4'd10;

    typedef struct packed {
        t_uop   op;
        t_ucond cond;
        t_upc   target;
    } t_uword;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_cmd;

    // Control store: on a taken condition jump to target, else fall through
    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        case (pc)
            UPC_FETCH:    w = '{UOP_ACCEPT,    COND_NO_INPUT,     UPC_FETCH};
            UPC_DISPATCH: w = '{UOP_COMMAND,   COND_NO_NOTE_TICK, UPC_EMIT};
            UPC_TEST:     w = '{UOP_NOP,       COND_PHASE_ON,     UPC_ADVANCE};
            UPC_BEGIN:    w = '{UOP_BEGIN,     COND_ALWAYS,       UPC_DIV_LOAD};
            UPC_ADVANCE:  w = '{UOP_ADVANCE,   COND_NO_PROGRAM,   UPC_EMIT};
            UPC_DIV_LOAD: w = '{UOP_DIV_LOAD,  COND_NEVER,        UPC_FETCH};
            UPC_DIV_STEP: w = '{UOP_DIV_STEP,  COND_DIV_BUSY,     UPC_DIV_STEP};
            UPC_MUL:      w = '{UOP_SCALE_MUL, COND_NEVER,        UPC_FETCH};
            UPC_SCALE:    w = '{UOP_SCALE_OUT, COND_NEVER,        UPC_FETCH};
            UPC_EMIT:     w = '{UOP_EMIT,      COND_OUT_STALL,    UPC_EMIT};
            UPC_RETURN:   w = '{UOP_NOP,       COND_ALWAYS,       UPC_FETCH};
            default:      w = '{UOP_NOP,       COND_ALWAYS,       UPC_FETCH};
        endcase
        return w;
    endfunction

    function automatic t_note mk_note(input logic [FREQ_W-1:0] f, input logic [DUR_W-1:0] d);
        t_note n;
        n.freq = f;
        n.dur  = d;
        return n;
    endfunction

    function automatic logic [CNT_W-1:0] preset_len(input logic [TUNE_W-1:0] tune);
        logic [CNT_W-1:0] len;
        case (tune)
            TUNE_CLICK:     len = 3'd2;
            TUNE_POWER_ON:  len = 3'd6;
            TUNE_LOW_POWER: len = 3'd1;
            TUNE_WORK:      len = 3'd3;
            TUNE_PAIR:      len = 3'd5;
            default:        len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic t_note preset_note(input logic [TUNE_W-1:0] tune,
                                          input logic [POS_W-1:0]  pos);
        t_note n;
        n = '0;
        case (tune)
            TUNE_CLICK: begin
                case (pos)
                    3'd0:    n = mk_note(17'd440,  16'd80);
                    3'd1:    n = mk_note(17'd587,  16'd80);
                    3'd2:    n = mk_note(17'd1912, 16'd60);
                    3'd3:    n = mk_note(17'd784,  16'd60);
                    3'd4:    n = mk_note(17'd3030, 16'd60);
                    3'd5:    n = mk_note(17'd3080, 16'd60);
                    default: n = '0;
                endcase
            end
            TUNE_POWER_ON: begin
                case (pos)
                    3'd0:    n = mk_note(17'd523, 16'd100);
                    3'd1:    n = mk_note(17'd587, 16'd100);
                    3'd2:    n = mk_note(17'd659, 16'd80);
                    3'd3:    n = mk_note(17'd784, 16'd60);
                    3'd4:    n = mk_note(17'd880, 16'd60);
                    3'd5:    n = mk_note(17'd988, 16'd60);
                    default: n = '0;
                endcase
            end
            TUNE_LOW_POWER: begin
                case (pos)
                    3'd0:    n = mk_note(17'd1274,   16'd100);
                    3'd1:    n = mk_note(17'd100000, 16'd20);
                    3'd2:    n = mk_note(17'd1912,   16'd60);
                    3'd3:    n = mk_note(17'd100000, 16'd20);
                    3'd4:    n = mk_note(17'd3030,   16'd60);
                    3'd5:    n = mk_note(17'd100000, 16'd20);
                    default: n = '0;
                endcase
            end
            TUNE_WORK: begin
                case (pos)
                    3'd0:    n = mk_note(17'd1274, 16'd100);
                    3'd1:    n = mk_note(17'd954,  16'd100);
                    3'd2:    n = mk_note(17'd1912, 16'd100);
                    default: n = '0;
                endcase
            end
            TUNE_PAIR: begin
                case (pos)
                    3'd0:    n = mk_note(17'd1016, 16'd100);
                    3'd1:    n = mk_note(17'd1252, 16'd60);
                    3'd2:    n = mk_note(17'd1512, 16'd100);
                    3'd3:    n = mk_note(17'd1984, 16'd60);
                    3'd4:    n = mk_note(17'd2230, 16'd100);
                    3'd5:    n = mk_note(17'd3080, 16'd60);
                    default: n = '0;
                endcase
            end
            default: n = '0;
        endcase
        return n;
    endfunction

endpackage

/* rtl/bms_div.sv */
module bms_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bms_pkg::t_div_cmd             i_cmd,
    input  logic [bms_pkg::FREQ_W-1:0]    i_divisor,
    output logic [bms_pkg::PERIOD_W-1:0]  o_quotient,
    output logic                          o_last
);
    import bms_pkg::*;

    // Restoring division of the PWM clock by the note frequency, one bit per step
    logic [FREQ_W-1:0]    r_rem;
    logic [PERIOD_W-1:0]  r_quo;
    logic [FREQ_W-1:0]    r_divisor;
    logic [DIV_CNT_W-1:0] r_count;

    logic [FREQ_W:0] w_shift;
    logic [FREQ_W:0] w_diff;
    logic            w_fits;

    always_comb begin
        w_shift = {r_rem, r_quo[PERIOD_W-1]};
        w_diff  = w_shift - {1'b0, r_divisor};
        w_fits  = (w_shift >= {1'b0, r_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= DIV_LAST;
        end else if (i_cmd.step && (r_count != '0)) begin
            r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem     <= '0;
            r_quo     <= PWM_CLOCK;
            r_divisor <= i_divisor;
        end else if (i_cmd.step) begin
            r_rem <= w_fits ? w_diff[FREQ_W-1:0] : w_shift[FREQ_W-1:0];
            r_quo <= {r_quo[PERIOD_W-2:0], w_fits};
        end
    end

    assign o_quotient = r_quo;
    assign o_last     = (r_count == '0);

endmodule

/* rtl/buzzer_melody_sequencer.sv */
// Buzzer melody sequencer. Send a play transaction (tuser kind 1 with a preset id in tdata,
// or kind 2 for the custom tune held in the configuration registers) to enable the buzzer,
// then send tick transactions (kind 0) from a periodic timer; kind 3 stops the output and
// keeps the place in the tune. Every input transaction returns exactly one output
// transaction: pwm_on, and when reprogram (tuser) is set the PWM period, high and low counts
// for the note just loaded; tlast marks the tick on which the last note finished. Control
// runs from an 11-step microcode store with a step counter and conditional jumps. Play,
// stop and idle ticks go from dispatch straight to the result; a tick that advances the
// elapsed time without a note change also passes the test and advance steps; a tick that
// loads a note also runs the 26-step serial divider computing 40000000 / frequency and
// the scaling steps. A result waits while the downstream ready is low. A new input is
// taken only when the previous one has been handed to the output register, which may
// still be waiting on the downstream ready. Configuration writes take effect at once;
// write them only while idle.
`include "buzzer_melody_sequencer_assert.svh"

module buzzer_melody_sequencer #(
    parameter int TICK_STEP = bms_pkg::TICK_STEP,
    parameter int MAX_NOTES = bms_pkg::MAX_NOTES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_wr_en,
    input  logic [bms_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bms_pkg::NOTE_W-1:0]        i_cfg_data,
    // Input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [7:0]                        i_s_axis_tdata,  // [2:0] tune_id, rest zero
    input  logic [1:0]                        i_s_axis_tuser,  // [1:0] kind
    // Result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] pwm_on, [26:1] period_count, [49:27] high_count, [75:50] low_count, [79:76] zero
    output logic [79:0]                       o_m_axis_tdata,
    output logic [0:0]                        o_m_axis_tuser,  // [0] reprogram
    output logic                              o_m_axis_tlast   // tune_done
);
    import bms_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_NOTES);

    // Sequencer
    t_upc   r_pc, n_pc;
    t_uword w_uw;
    logic   w_jump;

    // Latched input transaction
    t_kind             r_kind, n_kind;
    logic [TUNE_W-1:0] r_tune_id, n_tune_id;

    // Player state
    logic                 r_phase, n_phase;
    logic [TUNE_W-1:0]    r_select, n_select;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic                 r_running, n_running;
    logic [CNT_W-1:0]     r_copy_count, n_copy_count;
    t_note                r_copy [STORED_NOTES];
    t_note                n_copy [STORED_NOTES];

    // Configuration registers
    logic [CNT_W-1:0] r_cfg_count, n_cfg_count;
    t_note            r_cfg_note [STORED_NOTES];
    t_note            n_cfg_note [STORED_NOTES];

    // Result build-up
    logic                 r_res_reprogram, n_res_reprogram;
    logic                 r_res_done, n_res_done;
    logic                 r_freq_zero, n_freq_zero;
    logic [PERIOD_W-1:0]  r_period, n_period;
    logic [HIGH_W-1:0]    r_high, n_high;
    logic [PERIOD_W-1:0]  r_low, n_low;
    logic [PRODUCT_W-1:0] r_product, n_product;

    // Output register
    logic                r_out_valid, n_out_valid;
    logic                r_out_pwm_on, n_out_pwm_on;
    logic                r_out_reprogram, n_out_reprogram;
    logic                r_out_done, n_out_done;
    logic [PERIOD_W-1:0] r_out_period, n_out_period;
    logic [HIGH_W-1:0]   r_out_high, n_out_high;
    logic [PERIOD_W-1:0] r_out_low, n_out_low;

    // Datapath helpers
    t_note                w_note;
    logic [CNT_W-1:0]     w_count;
    logic [LEN_W-1:0]     w_len;
    logic [ELAPSED_W:0]   w_elapsed_sum;
    logic [ELAPSED_W-1:0] w_elapsed_sat;
    logic                 w_reached;
    logic [POS_W-1:0]     w_pos_next;
    logic                 w_end;
    logic                 w_out_stall;
    logic [PERIOD_W-1:0]  w_period_sel;
    logic [HIGH_W-1:0]    w_high;

    t_div_cmd             w_div_cmd;
    logic [PERIOD_W-1:0]  w_quotient;
    logic                 w_div_last;

    bms_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_div_cmd),
        .i_divisor  (w_note.freq),
        .o_quotient (w_quotient),
        .o_last     (w_div_last)
    );

    // Note at the current position of the selected tune; absent notes read as zero
    always_comb begin
        w_note = '0;
        if (r_pos <= STORED_LAST) begin
            if (r_select < TUNE_CUSTOM) begin
                w_note = preset_note(r_select, r_pos);
            end else if (r_select == TUNE_CUSTOM) begin
                w_note = r_copy[r_pos];
            end
        end
    end

    // Tune length, limited to the note budget
    always_comb begin
        w_count = '0;
        if (r_select < TUNE_CUSTOM) begin
            w_count = preset_len(r_select);
        end else if (r_select == TUNE_CUSTOM) begin
            w_count = r_copy_count;
        end
        w_len = ({1'b0, w_count} > MAX_LEN) ? MAX_LEN : {1'b0, w_count};
    end

    // Elapsed time update and end-of-note / end-of-tune tests
    always_comb begin
        w_elapsed_sum = {1'b0, r_elapsed} + (ELAPSED_W + 1)'(TICK_STEP);
        w_elapsed_sat = (w_elapsed_sum > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX
                                                              : w_elapsed_sum[ELAPSED_W-1:0];
        w_reached     = (w_elapsed_sat >= {1'b0, w_note.dur});
        w_pos_next    = r_pos + 1'b1;
        w_end         = ({1'b0, w_pos_next} >= w_len) || ({1'b0, w_pos_next} >= MAX_LEN);
    end

    assign w_out_stall  = r_out_valid && !i_m_axis_tready;
    assign w_period_sel = r_freq_zero ? PERIOD_MAX : w_quotient;
    assign w_high       = r_product[RECIP_SHIFT +: HIGH_W];

    // Fetch the control word and resolve its jump
    always_comb begin
        w_uw = ucode(r_pc);
        case (w_uw.cond)
            COND_NEVER:        w_jump = 1'b0;
            COND_ALWAYS:       w_jump = 1'b1;
            COND_NO_INPUT:     w_jump = !i_s_axis_tvalid;
            COND_NO_NOTE_TICK: w_jump = (r_kind != KIND_TICK) || !r_running ||
                                        (r_select == TUNE_NONE);
            COND_PHASE_ON:     w_jump = r_phase;
            COND_NO_PROGRAM:   w_jump = !w_reached || w_end;
            COND_DIV_BUSY:     w_jump = !w_div_last;
            COND_OUT_STALL:    w_jump = w_out_stall;
            default:           w_jump = 1'b1;
        endcase
        n_pc = w_jump ? w_uw.target : (r_pc + 1'b1);
    end

    assign o_s_axis_tready = (r_pc == UPC_FETCH);

    // Datapath driven by the current micro-operation
    always_comb begin
        n_kind          = r_kind;
        n_tune_id       = r_tune_id;
        n_phase         = r_phase;
        n_select        = r_select;
        n_pos           = r_pos;
        n_elapsed       = r_elapsed;
        n_running       = r_running;
        n_copy_count    = r_copy_count;
        n_copy          = r_copy;
        n_cfg_count     = r_cfg_count;
        n_cfg_note      = r_cfg_note;
        n_res_reprogram = r_res_reprogram;
        n_res_done      = r_res_done;
        n_freq_zero     = r_freq_zero;
        n_period        = r_period;
        n_high          = r_high;
        n_low           = r_low;
        n_product       = r_product;
        n_out_valid     = r_out_valid && !i_m_axis_tready;
        n_out_pwm_on    = r_out_pwm_on;
        n_out_reprogram = r_out_reprogram;
        n_out_done      = r_out_done;
        n_out_period    = r_out_period;
        n_out_high      = r_out_high;
        n_out_low       = r_out_low;
        w_div_cmd       = '0;

        case (w_uw.op)
            UOP_ACCEPT: begin
                // Take the transaction and clear the result fields
                if (i_s_axis_tvalid) begin
                    n_kind          = t_kind'(i_s_axis_tuser);
                    n_tune_id       = i_s_axis_tdata[TUNE_W-1:0];
                    n_res_reprogram = 1'b0;
                    n_res_done      = 1'b0;
                    n_period        = '0;
                    n_high          = '0;
                    n_low           = '0;
                end
            end
            UOP_COMMAND: begin
                case (r_kind)
                    KIND_PRESET: begin
                        // Unknown preset ids keep the current selection
                        if (r_tune_id < TUNE_CUSTOM) begin
                            n_select = r_tune_id;
                        end
                        n_running = 1'b1;
                    end
                    KIND_CUSTOM: begin
                        n_copy       = r_cfg_note;
                        n_copy_count = r_cfg_count;
                        n_select     = TUNE_CUSTOM;
                        n_running    = 1'b1;
                    end
                    KIND_STOP: begin
                        n_running = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            UOP_BEGIN: begin
                n_elapsed = '0;
                n_pos     = '0;
                n_phase   = 1'b1;
            end
            UOP_ADVANCE: begin
                n_elapsed = w_reached ? '0 : w_elapsed_sat;
                if (w_reached) begin
                    if (w_end) begin
                        n_running  = 1'b0;
                        n_phase    = 1'b0;
                        n_select   = TUNE_NONE;
                        n_pos      = '0;
                        n_res_done = 1'b1;
                    end else begin
                        n_pos = w_pos_next;
                    end
                end
            end
            UOP_DIV_LOAD: begin
                w_div_cmd.load = 1'b1;
                n_freq_zero    = (w_note.freq == '0);
            end
            UOP_DIV_STEP: begin
                w_div_cmd.step = 1'b1;
            end
            UOP_SCALE_MUL: begin
                // Zero frequency saturates the period
                n_period  = w_period_sel;
                n_product = {{(PRODUCT_W - PERIOD_W){1'b0}}, w_period_sel} *
                            {{(PRODUCT_W - RECIP_W){1'b0}}, RECIP_10};
            end
            UOP_SCALE_OUT: begin
                n_high          = w_high;
                n_low           = {w_high, 3'b000} + {3'b000, w_high};
                n_res_reprogram = 1'b1;
            end
            UOP_EMIT: begin
                // Hold while the output register still waits on downstream
                if (!w_out_stall) begin
                    n_out_valid     = 1'b1;
                    n_out_pwm_on    = r_running;
                    n_out_reprogram = r_res_reprogram;
                    n_out_done      = r_res_done;
                    n_out_period    = r_period;
                    n_out_high      = r_high;
                    n_out_low       = r_low;
                end
            end
            default: begin
            end
        endcase

        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_NOTE_COUNT: n_cfg_count   = i_cfg_data[CNT_W-1:0];
                CFG_NOTE_0:     n_cfg_note[0] = i_cfg_data;
                CFG_NOTE_1:     n_cfg_note[1] = i_cfg_data;
                CFG_NOTE_2:     n_cfg_note[2] = i_cfg_data;
                CFG_NOTE_3:     n_cfg_note[3] = i_cfg_data;
                CFG_NOTE_4:     n_cfg_note[4] = i_cfg_data;
                CFG_NOTE_5:     n_cfg_note[5] = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= UPC_FETCH;
            r_phase      <= 1'b0;
            r_select     <= TUNE_NONE;
            r_pos        <= '0;
            r_elapsed    <= '0;
            r_running    <= 1'b0;
            r_copy_count <= '0;
            r_cfg_count  <= 3'd1;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < STORED_NOTES; i++) begin
                r_copy[i]     <= '0;
                r_cfg_note[i] <= '0;
            end
            r_cfg_note[0] <= NOTE_RESET_0;
        end else begin
            r_pc         <= n_pc;
            r_phase      <= n_phase;
            r_select     <= n_select;
            r_pos        <= n_pos;
            r_elapsed    <= n_elapsed;
            r_running    <= n_running;
            r_copy_count <= n_copy_count;
            r_cfg_count  <= n_cfg_count;
            r_out_valid  <= n_out_valid;
            r_copy       <= n_copy;
            r_cfg_note   <= n_cfg_note;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_kind          <= n_kind;
        r_tune_id       <= n_tune_id;
        r_res_reprogram <= n_res_reprogram;
        r_res_done      <= n_res_done;
        r_freq_zero     <= n_freq_zero;
        r_period        <= n_period;
        r_high          <= n_high;
        r_low           <= n_low;
        r_product       <= n_product;
        r_out_pwm_on    <= n_out_pwm_on;
        r_out_reprogram <= n_out_reprogram;
        r_out_done      <= n_out_done;
        r_out_period    <= n_out_period;
        r_out_high      <= n_out_high;
        r_out_low       <= n_out_low;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_low, r_out_high, r_out_period, r_out_pwm_on};
    assign o_m_axis_tuser  = r_out_reprogram;
    assign o_m_axis_tlast  = r_out_done;

    // A cleared selection always goes with the waiting phase
    `BMS_ASSERT_IMP(a_idle_phase, r_select == TUNE_NONE, !r_phase,
                    "phase active with no tune selected")
    // An accepted transaction goes straight to dispatch
    `BMS_ASSERT_NXT(a_accept_dispatch, i_s_axis_tvalid && o_s_axis_tready,
                    r_pc == UPC_DISPATCH, "accepted transaction not dispatched")
    // A finished tune leaves the buzzer off and loads no note
    `BMS_ASSERT_IMP(a_done_off, r_out_valid && r_out_done,
                    !r_out_pwm_on && !r_out_reprogram, "tune end with output still active")
    // A loaded note comes with the buzzer on and a nonzero period
    `BMS_ASSERT_IMP(a_reprogram_on, r_out_valid && r_out_reprogram,
                    r_out_pwm_on && (r_out_period != '0), "bad reprogram result")

endmodule

/* test/tb_buzzer_melody_sequencer.sv */
module tb_buzzer_melody_sequencer;
    import bms_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_TARGET = 1850;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_TICK_CAP = 60;

    localparam int unsigned TONE_CLOCK = 40_000_000;
    localparam int unsigned PERIOD_CEIL = 67_108_863;
    localparam int unsigned ELAPSED_CEIL = 131_071;

    // Preset tunes, one row per tune id
    localparam int unsigned ROM_LEN[5] = '{2, 6, 1, 3, 5};
    localparam int unsigned ROM_FREQ[5][6] = '{
        '{440, 587, 1912, 784, 3030, 3080},
        '{523, 587, 659, 784, 880, 988},
        '{1274, 100000, 1912, 100000, 3030, 100000},
        '{1274, 954, 1912, 0, 0, 0},
        '{1016, 1252, 1512, 1984, 2230, 3080}
    };
    localparam int unsigned ROM_DUR[5][6] = '{
        '{80, 80, 60, 60, 60, 60},
        '{100, 100, 80, 60, 60, 60},
        '{100, 20, 60, 20, 60, 20},
        '{100, 100, 100, 0, 0, 0},
        '{100, 60, 100, 60, 100, 60}
    };

    typedef struct packed {
        bit        pwm_on;
        bit        reprogram;
        bit [25:0] period;
        bit [22:0] high;
        bit [25:0] low;
        bit        done;
    } pwm_result_t;

    // Shadow of the player: registers, play state and the PWM settings still owed
    class melody_scoreboard;
        bit [CNT_W-1:0]     reg_count;
        t_note              reg_note[STORED_NOTES];
        bit                 playing;
        bit [TUNE_W-1:0]    sel;
        bit [POS_W-1:0]     pos;
        int unsigned        elapsed;
        bit                 running;
        t_note              tune_copy[STORED_NOTES];
        bit [CNT_W-1:0]     count_copy;
        pwm_result_t        expected_pwm[$];
        int                 errors;

        function new();
            reg_count = 1;
            foreach (reg_note[i]) begin
                reg_note[i] = '0;
                tune_copy[i] = '0;
            end
            reg_note[0] = 33'd131073000;
            playing = 0;
            sel = TUNE_NONE;
            pos = 0;
            elapsed = 0;
            running = 0;
            count_copy = 0;
            errors = 0;
        endfunction

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [NOTE_W-1:0] data);
            if (idx == CFG_NOTE_COUNT) begin
                reg_count = data[CNT_W-1:0];
            end else if (idx >= CFG_NOTE_0 && idx <= CFG_NOTE_5) begin
                reg_note[idx - CFG_NOTE_0] = data;
            end
        endfunction

        function void note_at(output int unsigned f, output int unsigned d);
            f = 0;
            d = 0;
            if (pos < STORED_NOTES) begin
                if (sel < PRESET_COUNT) begin
                    f = ROM_FREQ[sel][pos];
                    d = ROM_DUR[sel][pos];
                end else if (sel == TUNE_CUSTOM) begin
                    f = 32'(tune_copy[pos].freq);
                    d = 32'(tune_copy[pos].dur);
                end
            end
        endfunction

        function int unsigned notes_in_tune();
            int unsigned c;
            c = 0;
            if (sel < PRESET_COUNT) c = ROM_LEN[sel];
            else if (sel == TUNE_CUSTOM) c = 32'(count_copy);
            if (c > MAX_NOTES) c = MAX_NOTES;
            return c;
        endfunction

        // Compute period, high and low counts for the note at the current position
        function void load_note(inout pwm_result_t r);
            int unsigned f, d, period, high;
            note_at(f, d);
            period = (f == 0) ? PERIOD_CEIL : TONE_CLOCK / f;
            if (period > PERIOD_CEIL) period = PERIOD_CEIL;
            high = period / 10;
            r.reprogram = 1'b1;
            r.period = period[25:0];
            r.high = high[22:0];
            r.low = 26'(high * 9);
        endfunction

        function void note_input(t_kind kind, bit [2:0] id);
            pwm_result_t r;
            int unsigned f, d;
            r = '0;
            case (kind)
                KIND_PRESET: begin
                    // unknown ids keep the current tune but still enable output
                    if (id < PRESET_COUNT) sel = id;
                    running = 1;
                end
                KIND_CUSTOM: begin
                    tune_copy = reg_note;
                    count_copy = reg_count;
                    sel = TUNE_CUSTOM;
                    running = 1;
                end
                KIND_STOP: begin
                    running = 0;
                end
                default: begin
                    if (running && sel != TUNE_NONE) begin
                        if (!playing) begin
                            elapsed = 0;
                            pos = 0;
                            load_note(r);
                            playing = 1;
                        end else begin
                            note_at(f, d);
                            elapsed += TICK_STEP;
                            if (elapsed > ELAPSED_CEIL) elapsed = ELAPSED_CEIL;
                            if (elapsed >= d) begin
                                elapsed = 0;
                                pos = pos + 1'b1;
                                if (pos >= notes_in_tune() || pos >= MAX_NOTES) begin
                                    running = 0;
                                    playing = 0;
                                    sel = TUNE_NONE;
                                    pos = 0;
                                    r.done = 1'b1;
                                end else begin
                                    load_note(r);
                                end
                            end
                        end
                    end
                end
            endcase
            r.pwm_on = running;
            expected_pwm.push_back(r);
        endfunction

        function void check_result(bit [79:0] data, bit user, bit last);
            pwm_result_t want, got;
            got.pwm_on = data[0];
            got.period = data[26:1];
            got.high = data[49:27];
            got.low = data[75:50];
            got.reprogram = user;
            got.done = last;
            if (expected_pwm.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result with nothing pending: pwm_on=%0d reprogram=%0d",
                             got.pwm_on, got.reprogram);
                return;
            end
            want = expected_pwm.pop_front();
            if (got != want) begin
                errors++;
                if (errors <= 10) begin
                    $display("ERROR: pwm_on %0d/%0d reprogram %0d/%0d period %0d/%0d",
                             want.pwm_on, got.pwm_on, want.reprogram, got.reprogram,
                             want.period, got.period);
                    $display("       high %0d/%0d low %0d/%0d done %0d/%0d (expected/actual)",
                             want.high, got.high, want.low, got.low, want.done, got.done);
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [NOTE_W-1:0]     cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [79:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;

    melody_scoreboard sb = new();
    int  cycles = 0;
    int  counted_items = 0;
    int  burst_left = 0;
    int  ready_run = 0;
    bit  stall_on = 1'b1;

    buzzer_melody_sequencer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_we),
        .i_cfg_index     (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    // Watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: alternate runs of ready and stall; stalls only while stall_on is set
    always @(negedge clk) begin
        if (ready_run == 0) begin
            if (m_tready && stall_on) begin
                m_tready <= 1'b0;
                ready_run = $urandom_range(1, 6);
            end else begin
                m_tready <= 1'b1;
                ready_run = $urandom_range(1, 12);
            end
        end else begin
            ready_run--;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0], m_tlast);

    // Present one transaction; the sender works in bursts with random gaps between them
    task automatic send_item(input t_kind kind, input bit [2:0] id);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, id};
        s_tuser <= kind;
        do @(posedge clk); while (!s_tready);
        // ticks that the block ignores do not count toward the target
        if (kind != KIND_TICK || (sb.running && sb.sel != TUNE_NONE)) counted_items++;
        sb.note_input(kind, id);
    endtask

    // Hold off until every result is back and the block has settled
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.expected_pwm.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input bit [CFG_IDX_W-1:0] idx, input bit [NOTE_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic t_note random_note();
        t_note n;
        case ($urandom_range(0, 5))
            0:       n.freq = '0;
            1:       n.freq = 17'd1;
            2:       n.freq = '1;
            3, 4:    n.freq = 17'($urandom_range(100, 5000));
            default: n.freq = 17'($urandom);
        endcase
        // keep most durations short so tunes run to their end
        case ($urandom_range(0, 19))
            0:       n.dur = '0;
            1:       n.dur = '1;
            2:       n.dur = 16'($urandom);
            default: n.dur = 16'($urandom_range(1, 120));
        endcase
        return n;
    endfunction

    initial begin
        int phase;
        int ticks;
        t_note n;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero count, zero frequency and zero duration in the custom tune
        write_reg(CFG_NOTE_COUNT, 0);
        write_reg(CFG_NOTE_0, '0);
        send_item(KIND_TICK, 3'd0);      // stopped: no effect
        send_item(KIND_STOP, 3'd7);
        send_item(KIND_PRESET, 3'd6);    // unknown id, no tune yet
        send_item(KIND_TICK, 3'd5);      // enabled but nothing selected
        send_item(KIND_CUSTOM, 3'd2);
        send_item(KIND_TICK, 3'd0);      // saturated period
        send_item(KIND_TICK, 3'd1);      // zero duration ends the tune
        send_item(KIND_TICK, 3'd0);
        send_item(KIND_PRESET, 3'd2);
        send_item(KIND_TICK, 3'd3);
        send_item(KIND_TICK, 3'd4);
        send_item(KIND_STOP, 3'd0);
        send_item(KIND_TICK, 3'd0);      // tick while stopped
        send_item(KIND_PRESET, 3'd7);    // resume the same tune
        send_item(KIND_TICK, 3'd0);
        send_item(KIND_PRESET, 3'd4);    // switch tune mid-play
        send_item(KIND_TICK, 3'd0);
        send_item(KIND_TICK, 3'd0);
        send_item(KIND_TICK, 3'd0);
        send_item(KIND_PRESET, 3'd3);
        send_item(KIND_TICK, 3'd0);
        send_item(KIND_STOP, 3'd5);
        drain();

        // Random phases: reprogram while idle, then start a tune and tick through it, or send a run of random items
        phase = 0;
        while (counted_items < ITEM_TARGET) begin
            stall_on = ($urandom_range(0, 3) != 0);
            if (phase < 2 || $urandom_range(0, 2) == 0) begin
                write_reg(CFG_NOTE_COUNT, NOTE_W'((phase == 0) ? 7 : (phase == 1) ? 6 :
                                                  $urandom_range(0, 7)));
                for (int i = 0; i < STORED_NOTES; i++) begin
                    if (phase == 0) n = '1;
                    else if (phase == 1) n = (i % 2) ? {17'h1FFFF, 16'd20} : {17'd1, 16'd0};
                    else n = random_note();
                    if (phase < 2 || $urandom_range(0, 1))
                        write_reg(CFG_IDX_W'(CFG_NOTE_0 + i), n);
                end
            end
            if (phase >= 2 && $urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(4, 16))
                    send_item(t_kind'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
            end else begin
                if (phase < 2 || $urandom_range(0, 1))
                    send_item(KIND_CUSTOM, 3'($urandom_range(0, 7)));
                else
                    send_item(KIND_PRESET, 3'($urandom_range(0, 7)));
                ticks = 0;
                while (sb.running && sb.sel != TUNE_NONE && ticks < PHASE_TICK_CAP) begin
                    if ($urandom_range(0, 15) == 0)
                        send_item(t_kind'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
                    else
                        send_item(KIND_TICK, 3'($urandom_range(0, 7)));
                    ticks++;
                end
            end
            drain();
            phase++;
        end

        if (sb.errors == 0 && sb.expected_pwm.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
